// ===== rtl/pbpm_pkg.sv =====
// ----------------------------------------------------------------------------
// pbpm_pkg
// Types, constants and prefix mask helpers of the prefix bypass packet marker.
// ----------------------------------------------------------------------------
package pbpm_pkg;

    localparam int V4_SKIP_ENTRIES_DEF = 512;
    localparam int V6_SKIP_ENTRIES_DEF = 512;
    localparam int NUM_CELLS = 8;
    localparam int CELL_BITS = 3;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_FRAME = 2'd1;
    localparam logic [1:0] ACT_CONN  = 2'd2;

    localparam logic [1:0] CFG_FWMARK   = 2'd0;
    localparam logic [1:0] CFG_LOOPBACK = 2'd1;
    localparam logic [1:0] CFG_PROXY    = 2'd2;

    localparam logic [15:0] FAMILY_V4 = 16'd2;
    localparam logic [15:0] FAMILY_V6 = 16'd10;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [15:0] ETYPE_V4  = 16'h0800;
    localparam logic [15:0] ETYPE_V6  = 16'h86DD;
    localparam logic [5:0]  V4_MIN_LEN = 6'd34;
    localparam logic [5:0]  V6_MIN_LEN = 6'd54;
    localparam logic [5:0]  COUNT_SAT  = 6'd54;
    localparam logic [7:0]  V4_MAX_PLEN = 8'd32;
    localparam logic [7:0]  V6_MAX_PLEN = 8'd128;

    typedef struct packed {
        logic vld;
        logic last;
        logic hit;
    } t_tok;

    typedef struct packed {
        logic        is_v6;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_key;

    typedef struct packed {
        logic        en4;
        logic        en6;
        logic        pfx_en;
        logic        valid;
        logic [5:0]  len4;
        logic [7:0]  len6;
        logic [31:0] pfx4;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_wr;

    function automatic logic [31:0] mask32(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0) begin
            m = 32'h0;
        end else if (len >= 6'd32) begin
            m = '1;
        end else begin
            m = ~32'h0 << (6'd32 - len);
        end
        return m;
    endfunction

    function automatic logic [63:0] mask64(input logic [7:0] len);
        logic [63:0] m;
        if (len == 8'd0) begin
            m = 64'h0;
        end else if (len >= 8'd64) begin
            m = '1;
        end else begin
            m = ~64'h0 << (8'd64 - len);
        end
        return m;
    endfunction

endpackage

// ===== rtl/prefix_bypass_packet_marker.sv =====
// ----------------------------------------------------------------------------
// prefix_bypass_packet_marker
// Frame marking and connection redirect verdicts against prefix skip tables.
// ----------------------------------------------------------------------------
// After reset the block clears both tables, one row of all cells per cycle,
// over max(ceil(V4/8), ceil(V6/8)) rows (64 at the defaults), and takes no
// item meanwhile. Loads and frame bytes other than the last leave it idle.
// A last frame byte or a connection item scans the tables through a chain of
// eight cells, one row per cycle; the verdict is registered once the last row
// has left the chain, and the block takes no new item until it has issued that
// verdict, which waits while an earlier result is still stalled.
module prefix_bypass_packet_marker #(
    parameter int V4_SKIP_ENTRIES = pbpm_pkg::V4_SKIP_ENTRIES_DEF,
    parameter int V6_SKIP_ENTRIES = pbpm_pkg::V6_SKIP_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [8:0]  i_entry_index,
    input  logic        i_entry_is_v6,
    input  logic [7:0]  i_entry_prefix_len,
    input  logic        i_entry_valid,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_last,
    input  logic [7:0]  i_conn_protocol,
    input  logic [31:0] i_conn_ifindex,
    input  logic [15:0] i_conn_family,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_verdict_kind,
    output logic        o_mark_applied,
    output logic [31:0] o_mark_value,
    output logic        o_redirect,
    output logic        o_address_skipped
);
    localparam int NC   = pbpm_pkg::NUM_CELLS;
    localparam int R4   = (V4_SKIP_ENTRIES + NC - 1) / NC;
    localparam int R6   = (V6_SKIP_ENTRIES + NC - 1) / NC;
    localparam int RMAX = (R4 > R6) ? R4 : R6;
    localparam int RW   = (RMAX > 1) ? $clog2(RMAX) : 1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state         r_state;
    logic [31:0]    r_fwmark;
    logic [31:0]    r_loopback;
    logic           r_proxy;
    logic [5:0]     r_cnt;
    logic [15:0]    r_type;
    logic [63:0]    r_dhi;
    logic [63:0]    r_dlo;
    pbpm_pkg::t_key r_key;
    logic           r_kind;
    logic           r_elig;
    logic           r_pre;
    logic [RW-1:0]  r_row;
    logic           r_inj;
    logic           r_acc;

    logic           w_accept;
    logic [5:0]     n_cnt;
    logic [15:0]    n_type;
    logic [63:0]    n_dhi;
    logic [63:0]    n_dlo;
    logic           w_fam_ok;
    logic           w_row_last;
    logic           w_skip;
    pbpm_pkg::t_wr  w_wr;
    logic [RW-1:0]  w_wr_row;
    logic [NC-1:0]  w_wr_sel;
    pbpm_pkg::t_tok w_tok [NC+1];
    logic [RW-1:0]  w_row [NC+1];

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_row_last = (r_row == RW'(RMAX - 1));
    assign w_fam_ok   = (i_conn_family == pbpm_pkg::FAMILY_V4) ||
                        (i_conn_family == pbpm_pkg::FAMILY_V6);
    assign w_skip     = r_acc | w_tok[NC].hit;

    always_comb begin
        n_type = r_type;
        n_dhi  = r_dhi;
        n_dlo  = r_dlo;
        if (r_cnt == 6'd12 || r_cnt == 6'd13) begin
            n_type = {r_type[7:0], i_frame_byte};
        end else if (r_cnt >= 6'd30 && r_cnt <= 6'd33 && r_type == pbpm_pkg::ETYPE_V4) begin
            n_dlo = {32'h0, r_dlo[23:0], i_frame_byte};
        end else if (r_cnt >= 6'd38 && r_cnt <= 6'd45 && r_type == pbpm_pkg::ETYPE_V6) begin
            n_dhi = {r_dhi[55:0], i_frame_byte};
        end else if (r_cnt >= 6'd46 && r_cnt <= 6'd53 && r_type == pbpm_pkg::ETYPE_V6) begin
            n_dlo = {r_dlo[55:0], i_frame_byte};
        end
        n_cnt = (r_cnt < pbpm_pkg::COUNT_SAT) ? r_cnt + 6'd1 : r_cnt;
    end

    always_comb begin
        w_wr        = '0;
        w_wr.valid  = i_entry_valid;
        w_wr.len4   = (i_entry_prefix_len > pbpm_pkg::V4_MAX_PLEN) ? 6'd32 : i_entry_prefix_len[5:0];
        w_wr.len6   = (i_entry_prefix_len > pbpm_pkg::V6_MAX_PLEN) ?
                      pbpm_pkg::V6_MAX_PLEN : i_entry_prefix_len;
        w_wr.pfx4   = i_addr_low[31:0];
        w_wr.hi     = i_addr_high;
        w_wr.lo     = i_addr_low;
        w_wr_row    = RW'(i_entry_index >> pbpm_pkg::CELL_BITS);
        w_wr_sel    = NC'(1) << i_entry_index[pbpm_pkg::CELL_BITS-1:0];
        if (r_state == S_CLEAR) begin
            w_wr.en4  = 1'b1;
            w_wr.en6  = 1'b1;
            w_wr.valid = 1'b0;
            w_wr_row  = r_row;
            w_wr_sel  = '1;
        end else if (w_accept && i_action == pbpm_pkg::ACT_LOAD) begin
            w_wr.en4    = !i_entry_is_v6 && (32'(i_entry_index) < V4_SKIP_ENTRIES);
            w_wr.en6    = i_entry_is_v6 && (32'(i_entry_index) < V6_SKIP_ENTRIES);
            w_wr.pfx_en = 1'b1;
        end
    end

    assign w_tok[0].vld  = (r_state == S_SCAN) && r_inj;
    assign w_tok[0].last = w_row_last;
    assign w_tok[0].hit  = 1'b0;
    assign w_row[0]      = r_row;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        pbpm_cell #(
            .R4 (R4),
            .R6 (R6),
            .RW (RW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (w_tok[g]),
            .i_row    (w_row[g]),
            .o_tok    (w_tok[g+1]),
            .o_row    (w_row[g+1]),
            .i_key    (r_key),
            .i_wr     (w_wr),
            .i_wr_row (w_wr_row),
            .i_wr_sel (w_wr_sel[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwmark   <= '0;
            r_loopback <= '0;
            r_proxy    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pbpm_pkg::CFG_FWMARK:   r_fwmark   <= i_cfg_data;
                pbpm_pkg::CFG_LOOPBACK: r_loopback <= i_cfg_data;
                pbpm_pkg::CFG_PROXY:    r_proxy    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_inj       <= 1'b0;
            r_acc       <= 1'b0;
            r_cnt       <= '0;
            r_type      <= '0;
            r_dhi       <= '0;
            r_dlo       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_row <= r_row + RW'(1);
                    if (w_row_last) begin
                        r_row   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_action)
                            pbpm_pkg::ACT_FRAME: begin
                                r_cnt  <= n_cnt;
                                r_type <= n_type;
                                r_dhi  <= n_dhi;
                                r_dlo  <= n_dlo;
                                if (i_frame_last) begin
                                    r_key.is_v6 <= (n_type == pbpm_pkg::ETYPE_V6);
                                    r_key.hi    <= n_dhi;
                                    r_key.lo    <= n_dlo;
                                    r_kind      <= 1'b0;
                                    r_elig      <= (n_type == pbpm_pkg::ETYPE_V4 &&
                                                    n_cnt >= pbpm_pkg::V4_MIN_LEN) ||
                                                   (n_type == pbpm_pkg::ETYPE_V6 &&
                                                    n_cnt >= pbpm_pkg::V6_MIN_LEN);
                                    r_pre       <= 1'b0;
                                    r_cnt       <= '0;
                                    r_type      <= '0;
                                    r_dhi       <= '0;
                                    r_dlo       <= '0;
                                    r_row       <= '0;
                                    r_inj       <= 1'b1;
                                    r_acc       <= 1'b0;
                                    r_state     <= S_SCAN;
                                end
                            end
                            pbpm_pkg::ACT_CONN: begin
                                r_key.is_v6 <= (i_conn_family == pbpm_pkg::FAMILY_V6);
                                r_key.hi    <= i_addr_high;
                                r_key.lo    <= i_addr_low;
                                r_kind      <= 1'b1;
                                r_elig      <= w_fam_ok;
                                r_pre       <= (i_conn_protocol == pbpm_pkg::PROTO_TCP) &&
                                               (r_loopback != 32'h0) &&
                                               (i_conn_ifindex == r_loopback) &&
                                               w_fam_ok && r_proxy;
                                r_row       <= '0;
                                r_inj       <= 1'b1;
                                r_acc       <= 1'b0;
                                r_state     <= S_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_inj) begin
                        if (w_row_last) begin
                            r_inj <= 1'b0;
                        end else begin
                            r_row <= r_row + RW'(1);
                        end
                    end
                    if (w_tok[NC].vld) begin
                        r_acc <= w_skip;
                        if (w_tok[NC].last) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid       <= 1'b1;
                        o_verdict_kind    <= r_kind;
                        o_address_skipped <= r_elig && r_acc;
                        o_redirect        <= r_kind && r_pre && !r_acc;
                        o_mark_applied    <= !r_kind && r_elig && !r_acc && (r_fwmark != 32'h0);
                        o_mark_value      <= (!r_kind && r_elig && !r_acc) ? r_fwmark : 32'h0;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

endmodule

// ===== rtl/pbpm_cell.sv =====
// ----------------------------------------------------------------------------
// pbpm_cell
// One cell of the match chain: holds a slice of both skip tables and ORs its
// own match of the current row into the token passed to the next cell.
// ----------------------------------------------------------------------------
module pbpm_cell #(
    parameter int R4 = 64,
    parameter int R6 = 64,
    parameter int RW = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pbpm_pkg::t_tok  i_tok,
    input  logic [RW-1:0]   i_row,
    output pbpm_pkg::t_tok  o_tok,
    output logic [RW-1:0]   o_row,
    input  pbpm_pkg::t_key  i_key,
    input  pbpm_pkg::t_wr   i_wr,
    input  logic [RW-1:0]   i_wr_row,
    input  logic            i_wr_sel
);
    localparam int AW4 = (R4 > 1) ? $clog2(R4) : 1;
    localparam int AW6 = (R6 > 1) ? $clog2(R6) : 1;

    logic [38:0]  r_mem4  [R4];
    logic [8:0]   r_mem6m [R6];
    logic [127:0] r_mem6p [R6];

    logic [38:0]    r_d4;
    logic [8:0]     r_d6m;
    logic [127:0]   r_d6p;
    logic           r_ok4;
    logic           r_ok6;
    pbpm_pkg::t_tok r_mid;
    logic [RW-1:0]  r_mid_row;
    logic           w_hit4;
    logic           w_hit6;
    logic [63:0]    w_mh;
    logic [63:0]    w_ml;

    always_ff @(posedge i_clk) begin
        if (i_wr_sel && i_wr.en4 && (i_wr_row < RW'(R4 - 1) || i_wr_row == RW'(R4 - 1))) begin
            r_mem4[i_wr_row[AW4-1:0]] <= {i_wr.valid, i_wr.len4, i_wr.pfx4};
        end
        if (i_wr_sel && i_wr.en6 && (i_wr_row < RW'(R6 - 1) || i_wr_row == RW'(R6 - 1))) begin
            r_mem6m[i_wr_row[AW6-1:0]] <= {i_wr.valid, i_wr.len6};
            if (i_wr.pfx_en) begin
                r_mem6p[i_wr_row[AW6-1:0]] <= {i_wr.hi, i_wr.lo};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d4      <= r_mem4[i_row[AW4-1:0]];
        r_d6m     <= r_mem6m[i_row[AW6-1:0]];
        r_d6p     <= r_mem6p[i_row[AW6-1:0]];
        r_ok4     <= (i_row < RW'(R4 - 1)) || (i_row == RW'(R4 - 1));
        r_ok6     <= (i_row < RW'(R6 - 1)) || (i_row == RW'(R6 - 1));
        r_mid_row <= i_row;
        o_row     <= r_mid_row;
    end

    always_comb begin
        w_mh   = pbpm_pkg::mask64(r_d6m[7:0]);
        w_ml   = (r_d6m[7:0] > 8'd64) ? pbpm_pkg::mask64(r_d6m[7:0] - 8'd64) : 64'h0;
        w_hit4 = r_ok4 && r_d4[38] &&
                 (((i_key.lo[31:0] ^ r_d4[31:0]) & pbpm_pkg::mask32(r_d4[37:32])) == 32'h0);
        w_hit6 = r_ok6 && r_d6m[8] &&
                 (((i_key.hi ^ r_d6p[127:64]) & w_mh) == 64'h0) &&
                 (((i_key.lo ^ r_d6p[63:0]) & w_ml) == 64'h0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= '0;
            o_tok <= '0;
        end else begin
            r_mid      <= i_tok;
            o_tok.vld  <= r_mid.vld;
            o_tok.last <= r_mid.last;
            o_tok.hit  <= r_mid.hit | (i_key.is_v6 ? w_hit6 : w_hit4);
        end
    end

endmodule

// ===== rtl/pbpm_checker.sv =====
// ----------------------------------------------------------------------------
// pbpm_checker
// Port level checks of the prefix bypass packet marker, bound to the top.
// ----------------------------------------------------------------------------
module pbpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_verdict_kind,
    input logic        o_mark_applied,
    input logic [31:0] o_mark_value,
    input logic        o_redirect,
    input logic        o_address_skipped
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("Result item dropped while stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result item valid after reset.");

    a_frame_no_redirect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_verdict_kind |-> !o_redirect)
        else $error("Frame verdict carries a redirect.");

    a_conn_no_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_verdict_kind |-> !o_mark_applied && o_mark_value == 32'h0)
        else $error("Connection verdict carries a mark.");

    a_mark_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mark_applied |-> !o_address_skipped && o_mark_value != 32'h0)
        else $error("Marked frame is skipped or has a zero mark.");

endmodule

bind prefix_bypass_packet_marker pbpm_checker u_pbpm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_verdict_kind    (o_verdict_kind),
    .o_mark_applied    (o_mark_applied),
    .o_mark_value      (o_mark_value),
    .o_redirect        (o_redirect),
    .o_address_skipped (o_address_skipped)
);
